// ===== design/dog_pkg.sv =====
`default_nettype none

package dog_pkg;

    localparam int MODULES_DEF = 8;
    localparam int CHANNELS = 16;
    localparam int CHAN_STRIDE = 16;

    localparam int CFG_W = 23;
    localparam int CFG_IDX_W = 3;

    localparam logic [1:0] KIND_MODULE = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_END = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_NARROW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_MID = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_WIDE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MODULE_TYPES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IO_RATE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MEMORY_SLOTS = 3'd5;

    localparam logic [1:0] MTYPE_MID = 2'd1;
    localparam logic [1:0] MTYPE_WIDE = 2'd2;

    localparam logic [22:0] LIMIT_NARROW_RST = 23'd32767;
    localparam logic [22:0] LIMIT_MID_RST = 23'd131071;
    localparam logic [22:0] LIMIT_WIDE_RST = 23'd524287;
    localparam logic [15:0] MODULE_TYPES_RST = 16'd0;
    localparam logic [16:0] IO_RATE_RST = 17'd65536;
    localparam logic [8:0] MEMORY_SLOTS_RST = 9'd64;

    localparam logic [16:0] RATE_MAX = 17'd65536;
    localparam logic [8:0] SLOTS_MAX = 9'd256;
    localparam logic [3:0] WRITE_SAT = 4'd10;

    typedef struct packed {
        logic [23:0] value;
        logic        ovf;
    } clip_res_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [15:0] cycle_rem;
        logic [7:0]  slot_rem;
    } wrap_res_t;

endpackage

`default_nettype wire

// ===== design/dog_clip.sv =====
`default_nettype none

module dog_clip
(
    input  wire logic signed [31:0] value_in,
    input  wire logic [1:0]         mtype,
    input  wire logic [22:0]        limit_narrow,
    input  wire logic [22:0]        limit_mid,
    input  wire logic [22:0]        limit_wide,
    output dog_pkg::clip_res_t      res
);

    logic [22:0]        lim;
    logic signed [32:0] lim_pos;
    logic signed [32:0] lim_neg;
    logic signed [32:0] v_ext;
    logic               over_hi;
    logic               over_lo;

    always_comb
    begin
        case (mtype)
            dog_pkg::MTYPE_MID:  lim = limit_mid;
            dog_pkg::MTYPE_WIDE: lim = limit_wide;
            default:             lim = limit_narrow;
        endcase
    end

    assign lim_pos = $signed({10'd0, lim});
    assign lim_neg = 33'sd0 - lim_pos;
    assign v_ext = {value_in[31], value_in};
    assign over_hi = v_ext > lim_pos;
    assign over_lo = v_ext < lim_neg;

    always_comb
    begin
        res.ovf = over_hi || over_lo;
        if (over_hi)
        begin
            res.value = lim_pos[23:0];
        end
        else if (over_lo)
        begin
            res.value = lim_neg[23:0];
        end
        else
        begin
            res.value = value_in[23:0];
        end
    end

endmodule

`default_nettype wire

// ===== design/dog_wrap_reduce.sv =====
`default_nettype none

module dog_wrap_reduce
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [15:0] cycle_val,
    input  wire logic [16:0] cycle_div,
    input  wire logic [7:0]  slot_val,
    input  wire logic [8:0]  slot_div,
    output dog_pkg::wrap_res_t res
);

    logic        busy_reg;
    logic        done_reg;
    logic [3:0]  step_reg;
    logic [16:0] rem_a_reg;
    logic [8:0]  rem_b_reg;
    logic [16:0] rem_a_next;
    logic [8:0]  rem_b_next;
    logic [17:0] sh_a;
    logic [9:0]  sh_b;
    logic [15:0] slot_ext;

    assign slot_ext = {8'd0, slot_val};

    // one quotient bit per cycle, msb first
    always_comb
    begin
        sh_a = {rem_a_reg, cycle_val[step_reg]};
        sh_b = {rem_b_reg, slot_ext[step_reg]};
        if (sh_a >= {1'b0, cycle_div})
        begin
            rem_a_next = 17'(sh_a - {1'b0, cycle_div});
        end
        else
        begin
            rem_a_next = sh_a[16:0];
        end
        if (sh_b >= {1'b0, slot_div})
        begin
            rem_b_next = 9'(sh_b - {1'b0, slot_div});
        end
        else
        begin
            rem_b_next = sh_b[8:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 4'd0;
            rem_a_reg <= 17'd0;
            rem_b_reg <= 9'd0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= 4'd15;
            rem_a_reg <= 17'd0;
            rem_b_reg <= 9'd0;
        end
        else if (busy_reg)
        begin
            rem_a_reg <= rem_a_next;
            rem_b_reg <= rem_b_next;
            step_reg <= step_reg - 4'd1;
            if (step_reg == 4'd0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign res.busy = busy_reg;
    assign res.done = done_reg;
    assign res.cycle_rem = rem_a_reg[15:0];
    assign res.slot_rem = rem_b_reg[7:0];

endmodule

`default_nettype wire

// ===== design/dac_output_guard_unit.sv =====
// an input beat is registered into stage one, then into the output registers
// throughput: one item per cycle, sustained with out_ready held high and no
// config write; a write to io_rate or memory_slots stalls input while the wrap
// remainders are recomputed one bit per cycle, any other write while cfg_we is high
// reset restores register defaults, sets the output enable and clears module
// enables, counters and status; overflow counters read zero via valid bits
`default_nettype none

module dac_output_guard_unit
#(
    parameter int MODULES = dog_pkg::MODULES_DEF
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [1:0]                      kind,
    input  wire logic [2:0]                      module_req,
    input  wire logic [3:0]                      channel,
    input  wire logic signed [16:0]              tag_cycle,
    input  wire logic signed [31:0]              sample,
    input  wire logic                            timing_error,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic signed [23:0]                   dac_value,
    output logic                                 overflow,
    output logic                                 forced_zero,
    output logic                                 clear_sample,
    output logic [31:0]                          overflow_count,
    output logic                                 module_ok,
    output logic [7:0]                           enable_mask,
    output logic                                 cycle_status,
    output logic [15:0]                          next_cycle,
    output logic [7:0]                           next_slot,
    output logic [3:0]                           write_enable_count,
    input  wire logic                            cfg_we,
    input  wire logic [dog_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [dog_pkg::CFG_W-1:0]       cfg_data
);

    localparam int MOD_W = (MODULES > 1) ? $clog2(MODULES) : 1;
    localparam int DEPTH = MODULES * dog_pkg::CHAN_STRIDE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [3:0] MOD_LIM = 4'(MODULES);
    localparam logic [4:0] CH_LIM = 5'(dog_pkg::CHANNELS);

    // configuration
    logic [22:0] limit_narrow_reg;
    logic [22:0] limit_mid_reg;
    logic [22:0] limit_wide_reg;
    logic [15:0] module_types_reg;
    logic [16:0] io_rate_reg;
    logic [8:0]  memory_slots_reg;

    // guard state
    logic        output_enable_reg;
    logic [7:0]  module_enable_reg;
    logic [15:0] missed_reg [MODULES];
    logic [15:0] expected_cycle_reg;
    logic [15:0] cycle_mod_reg;
    logic [7:0]  slot_index_reg;
    logic [7:0]  slot_mod_reg;
    logic [3:0]  written_cycles_reg;
    logic        status_flag_reg;

    // overflow counters
    logic [31:0]      ovf_mem [DEPTH];
    logic [DEPTH-1:0] ovf_vld_reg;

    // stage one
    logic              s1_valid_reg;
    logic [1:0]        s1_kind_reg;
    logic [2:0]        s1_m_reg;
    logic [3:0]        s1_c_reg;
    logic [16:0]       s1_tag_reg;
    logic signed [31:0] s1_sample_reg;
    logic              s1_terr_reg;
    logic [31:0]       s1_rd_reg;
    logic              s1_byp_reg;
    logic [31:0]       s1_byp_data_reg;

    // result
    logic              out_valid_reg;
    logic [23:0]       dac_value_reg;
    logic              overflow_reg;
    logic              forced_zero_reg;
    logic              clear_sample_reg;
    logic [31:0]       overflow_count_reg;
    logic              module_ok_reg;
    logic [7:0]        enable_mask_reg;
    logic              cycle_status_reg;
    logic [15:0]       next_cycle_reg;
    logic [7:0]        next_slot_reg;
    logic [3:0]        write_enable_count_reg;

    logic              in_accept;
    logic              s1_fire;
    logic              wrap_start;
    dog_pkg::wrap_res_t wrap;
    dog_pkg::clip_res_t clip;

    logic [6:0]        in_addr7;
    logic [ADDR_W-1:0] in_addr;
    logic [6:0]        s1_addr7;
    logic [ADDR_W-1:0] s1_addr;
    logic [MOD_W-1:0]  s1_midx;
    logic              m_ok;
    logic              c_ok;
    logic [7:0]        mbit;
    logic [15:0]       types_sh;
    logic [15:0]       missed_cur;
    logic [16:0]       rate_eff;
    logic [8:0]        slots_eff;
    logic [16:0]       cyc_inc;
    logic [8:0]        slot_inc;
    logic              forced;
    logic signed [31:0] v_pre;
    logic [31:0]       cnt_old;

    logic              oe_next;
    logic [7:0]        men_next;
    logic              missed_we;
    logic [15:0]       missed_next;
    logic              status_next;
    logic [15:0]       ec_next;
    logic [15:0]       cmod_next;
    logic [7:0]        sl_next;
    logic [7:0]        smod_next;
    logic [3:0]        wc_next;
    logic              mem_we;
    logic [31:0]       cnt_new;

    logic [23:0]       dac_value_next;
    logic              overflow_next;
    logic              forced_zero_next;
    logic              clear_sample_next;
    logic [31:0]       overflow_count_next;
    logic              module_ok_next;
    logic              cycle_status_next;
    logic [15:0]       next_cycle_next;
    logic [7:0]        next_slot_next;

    assign s1_fire = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !wrap.busy && !cfg_we && (!s1_valid_reg || s1_fire);
    assign in_accept = in_valid && in_ready;
    assign wrap_start = cfg_we
        && ((cfg_index == dog_pkg::REG_IO_RATE) || (cfg_index == dog_pkg::REG_MEMORY_SLOTS));

    assign in_addr7 = {module_req, channel};
    assign in_addr = in_addr7[ADDR_W-1:0];
    assign s1_addr7 = {s1_m_reg, s1_c_reg};
    assign s1_addr = s1_addr7[ADDR_W-1:0];
    assign s1_midx = s1_m_reg[MOD_W-1:0];
    assign m_ok = {1'b0, s1_m_reg} < MOD_LIM;
    assign c_ok = {1'b0, s1_c_reg} < CH_LIM;
    assign mbit = 8'd1 << s1_m_reg;
    assign types_sh = module_types_reg >> {s1_m_reg, 1'b0};
    assign missed_cur = m_ok ? missed_reg[s1_midx] : 16'd0;

    assign rate_eff = ((io_rate_reg == 17'd0) || (io_rate_reg > dog_pkg::RATE_MAX))
        ? dog_pkg::RATE_MAX : io_rate_reg;
    assign slots_eff = ((memory_slots_reg == 9'd0) || (memory_slots_reg > dog_pkg::SLOTS_MAX))
        ? dog_pkg::SLOTS_MAX : memory_slots_reg;
    assign cyc_inc = {1'b0, cycle_mod_reg} + 17'd1;
    assign slot_inc = {1'b0, slot_mod_reg} + 9'd1;

    assign forced = (missed_cur != 16'd0) || !output_enable_reg;
    assign v_pre = forced ? 32'sd0 : s1_sample_reg;
    assign cnt_old = s1_byp_reg ? s1_byp_data_reg
        : (ovf_vld_reg[s1_addr] ? s1_rd_reg : 32'd0);

    dog_clip u_clip
    (
        .value_in     (v_pre),
        .mtype        (types_sh[1:0]),
        .limit_narrow (limit_narrow_reg),
        .limit_mid    (limit_mid_reg),
        .limit_wide   (limit_wide_reg),
        .res          (clip)
    );

    dog_wrap_reduce u_wrap
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (wrap_start),
        .cycle_val (expected_cycle_reg),
        .cycle_div (rate_eff),
        .slot_val  (slot_index_reg),
        .slot_div  (slots_eff),
        .res       (wrap)
    );

    always_comb
    begin
        oe_next = output_enable_reg;
        men_next = module_enable_reg;
        missed_we = 1'b0;
        missed_next = (missed_cur == 16'hffff) ? missed_cur : missed_cur + 16'd1;
        status_next = status_flag_reg;
        ec_next = expected_cycle_reg;
        cmod_next = cycle_mod_reg;
        sl_next = slot_index_reg;
        smod_next = slot_mod_reg;
        wc_next = written_cycles_reg;
        mem_we = 1'b0;
        cnt_new = cnt_old;

        dac_value_next = 24'd0;
        overflow_next = 1'b0;
        forced_zero_next = 1'b0;
        clear_sample_next = 1'b0;
        overflow_count_next = 32'd0;
        module_ok_next = 1'b0;
        cycle_status_next = 1'b0;
        next_cycle_next = 16'd0;
        next_slot_next = 8'd0;

        case (s1_kind_reg)
            dog_pkg::KIND_MODULE:
            begin
                if (s1_terr_reg)
                begin
                    oe_next = 1'b0;
                end
                if (m_ok)
                begin
                    if (s1_tag_reg == {1'b0, expected_cycle_reg})
                    begin
                        men_next = module_enable_reg | mbit;
                        module_ok_next = 1'b1;
                    end
                    else
                    begin
                        men_next = module_enable_reg & ~mbit;
                        missed_we = 1'b1;
                    end
                end
            end
            dog_pkg::KIND_SAMPLE:
            begin
                if (!m_ok || !c_ok)
                begin
                    forced_zero_next = 1'b1;
                end
                else
                begin
                    forced_zero_next = forced;
                    clear_sample_next = !forced;
                    if (forced)
                    begin
                        status_next = 1'b1;
                    end
                    if (clip.ovf)
                    begin
                        cnt_new = (cnt_old == 32'hffff_ffff) ? cnt_old : cnt_old + 32'd1;
                        mem_we = 1'b1;
                    end
                    overflow_next = clip.ovf;
                    dac_value_next = output_enable_reg ? clip.value : 24'd0;
                    overflow_count_next = cnt_new;
                end
            end
            dog_pkg::KIND_END:
            begin
                cycle_status_next = status_flag_reg;
                status_next = 1'b0;
                cmod_next = (cyc_inc == rate_eff) ? 16'd0 : cyc_inc[15:0];
                smod_next = (slot_inc == slots_eff) ? 8'd0 : slot_inc[7:0];
                ec_next = cmod_next;
                sl_next = smod_next;
                if (written_cycles_reg < dog_pkg::WRITE_SAT)
                begin
                    wc_next = written_cycles_reg + 4'd1;
                end
                next_cycle_next = ec_next;
                next_slot_next = sl_next;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_narrow_reg <= dog_pkg::LIMIT_NARROW_RST;
            limit_mid_reg <= dog_pkg::LIMIT_MID_RST;
            limit_wide_reg <= dog_pkg::LIMIT_WIDE_RST;
            module_types_reg <= dog_pkg::MODULE_TYPES_RST;
            io_rate_reg <= dog_pkg::IO_RATE_RST;
            memory_slots_reg <= dog_pkg::MEMORY_SLOTS_RST;
            output_enable_reg <= 1'b1;
            module_enable_reg <= 8'd0;
            for (int i = 0; i < MODULES; i++)
            begin
                missed_reg[i] <= 16'd0;
            end
            expected_cycle_reg <= 16'd0;
            cycle_mod_reg <= 16'd0;
            slot_index_reg <= 8'd0;
            slot_mod_reg <= 8'd0;
            written_cycles_reg <= 4'd0;
            status_flag_reg <= 1'b0;
            ovf_vld_reg <= '0;
            s1_valid_reg <= 1'b0;
            s1_byp_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    dog_pkg::REG_LIMIT_NARROW: limit_narrow_reg <= cfg_data;
                    dog_pkg::REG_LIMIT_MID:    limit_mid_reg <= cfg_data;
                    dog_pkg::REG_LIMIT_WIDE:   limit_wide_reg <= cfg_data;
                    dog_pkg::REG_MODULE_TYPES: module_types_reg <= cfg_data[15:0];
                    dog_pkg::REG_IO_RATE:      io_rate_reg <= cfg_data[16:0];
                    dog_pkg::REG_MEMORY_SLOTS: memory_slots_reg <= cfg_data[8:0];
                    default:
                    begin
                    end
                endcase
            end

            if (wrap.done)
            begin
                cycle_mod_reg <= wrap.cycle_rem;
                slot_mod_reg <= wrap.slot_rem;
            end
            else if (s1_fire)
            begin
                cycle_mod_reg <= cmod_next;
                slot_mod_reg <= smod_next;
            end

            if (s1_fire)
            begin
                output_enable_reg <= oe_next;
                module_enable_reg <= men_next;
                if (missed_we)
                begin
                    missed_reg[s1_midx] <= missed_next;
                end
                status_flag_reg <= status_next;
                expected_cycle_reg <= ec_next;
                slot_index_reg <= sl_next;
                written_cycles_reg <= wc_next;
                if (mem_we)
                begin
                    ovf_vld_reg[s1_addr] <= 1'b1;
                end
            end

            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
                s1_byp_reg <= s1_fire && mem_we && (s1_addr == in_addr);
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // overflow counter memory, at most one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (s1_fire && mem_we)
        begin
            ovf_mem[s1_addr] <= cnt_new;
        end
        if (in_accept)
        begin
            s1_rd_reg <= ovf_mem[in_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_kind_reg <= kind;
            s1_m_reg <= module_req;
            s1_c_reg <= channel;
            s1_tag_reg <= tag_cycle;
            s1_sample_reg <= sample;
            s1_terr_reg <= timing_error;
            s1_byp_data_reg <= cnt_new;
        end
        if (s1_fire)
        begin
            dac_value_reg <= dac_value_next;
            overflow_reg <= overflow_next;
            forced_zero_reg <= forced_zero_next;
            clear_sample_reg <= clear_sample_next;
            overflow_count_reg <= overflow_count_next;
            module_ok_reg <= module_ok_next;
            enable_mask_reg <= men_next;
            cycle_status_reg <= cycle_status_next;
            next_cycle_reg <= next_cycle_next;
            next_slot_reg <= next_slot_next;
            write_enable_count_reg <= wc_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign dac_value = dac_value_reg;
    assign overflow = overflow_reg;
    assign forced_zero = forced_zero_reg;
    assign clear_sample = clear_sample_reg;
    assign overflow_count = overflow_count_reg;
    assign module_ok = module_ok_reg;
    assign enable_mask = enable_mask_reg;
    assign cycle_status = cycle_status_reg;
    assign next_cycle = next_cycle_reg;
    assign next_slot = next_slot_reg;
    assign write_enable_count = write_enable_count_reg;

    // no beat taken while wrap remainders are rebuilt
    a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        wrap.busy |-> !in_ready)
        else $error("input accepted during wrap recompute");

    a_wec_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (write_enable_count <= dog_pkg::WRITE_SAT))
        else $error("write enable count above saturation");

    a_forced_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && forced_zero) |-> (dac_value == 24'sd0))
        else $error("forced sample drives nonzero value");

    a_ovf_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && overflow) |-> (overflow_count != 32'd0))
        else $error("clipped sample with zero overflow count");

endmodule

`default_nettype wire
